// ----- rtl/takf_pkg.sv -----
// Package: shared types and constants for the tilt angle Kalman filter
package takf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_GAIN  = 3'd4;

    // ALU operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_MOV = 3'd5
    } alu_op_t;

    // Register file slots of the datapath
    typedef enum logic [4:0] {
        R_ANG  = 5'd0,  R_BIAS = 5'd1,  R_P00  = 5'd2,  R_P01  = 5'd3,
        R_P10  = 5'd4,  R_P11  = 5'd5,  R_MEAS = 5'd6,  R_RATE = 5'd7,
        R_DT   = 5'd8,  R_QA   = 5'd9,  R_QG   = 5'd10, R_RN   = 5'd11,
        R_C    = 5'd12, R_T0   = 5'd13, R_T1   = 5'd14, R_ERR  = 5'd15,
        R_D0   = 5'd16, R_D1   = 5'd17, R_PC0  = 5'd18, R_PC1  = 5'd19,
        R_E    = 5'd20, R_K0   = 5'd21, R_K1   = 5'd22, R_TT1  = 5'd23,
        R_CR   = 5'd24
    } reg_sel_t;

    typedef struct packed {
        logic     start;
        alu_op_t  op;
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
        logic     load_in;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

    // One microcode step: dst = src_a op src_b
    typedef struct packed {
        alu_op_t  op;
        reg_sel_t a;
        reg_sel_t b;
        reg_sel_t d;
    } ucode_t;

    localparam int unsigned PROG_LEN = 33;
    localparam int unsigned PC_W = 6;

    function automatic ucode_t program_step(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = '{OP_MOV, R_T0, R_T0, R_T0};
        case (pc)
            6'd0:  u = '{OP_SUB, R_RATE, R_BIAS, R_T0};
            6'd1:  u = '{OP_MUL, R_T0,   R_DT,   R_T0};
            6'd2:  u = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
            6'd3:  u = '{OP_SUB, R_MEAS, R_ANG,  R_ERR};
            6'd4:  u = '{OP_SUB, R_QA,   R_P01,  R_D0};
            6'd5:  u = '{OP_SUB, R_D0,   R_P10,  R_D0};
            6'd6:  u = '{OP_NEG, R_P11,  R_P11,  R_D1};
            6'd7:  u = '{OP_MUL, R_D0,   R_DT,   R_T0};
            6'd8:  u = '{OP_ADD, R_P00,  R_T0,   R_P00};
            6'd9:  u = '{OP_MUL, R_D1,   R_DT,   R_T0};
            6'd10: u = '{OP_ADD, R_P01,  R_T0,   R_P01};
            6'd11: u = '{OP_ADD, R_P10,  R_T0,   R_P10};
            6'd12: u = '{OP_MUL, R_QG,   R_DT,   R_T0};
            6'd13: u = '{OP_ADD, R_P11,  R_T0,   R_P11};
            6'd14: u = '{OP_MUL, R_C,    R_P00,  R_PC0};
            6'd15: u = '{OP_MUL, R_C,    R_P10,  R_PC1};
            6'd16: u = '{OP_MUL, R_C,    R_PC0,  R_T0};
            6'd17: u = '{OP_ADD, R_RN,   R_T0,   R_E};
            6'd18: u = '{OP_DIV, R_PC0,  R_E,    R_K0};
            6'd19: u = '{OP_DIV, R_PC1,  R_E,    R_K1};
            6'd20: u = '{OP_MUL, R_C,    R_P01,  R_TT1};
            6'd21: u = '{OP_MUL, R_K0,   R_PC0,  R_T0};
            6'd22: u = '{OP_SUB, R_P00,  R_T0,   R_P00};
            6'd23: u = '{OP_MUL, R_K0,   R_TT1,  R_T0};
            6'd24: u = '{OP_SUB, R_P01,  R_T0,   R_P01};
            6'd25: u = '{OP_MUL, R_K1,   R_PC0,  R_T0};
            6'd26: u = '{OP_SUB, R_P10,  R_T0,   R_P10};
            6'd27: u = '{OP_MUL, R_K1,   R_TT1,  R_T0};
            6'd28: u = '{OP_SUB, R_P11,  R_T0,   R_P11};
            6'd29: u = '{OP_MUL, R_K0,   R_ERR,  R_T0};
            6'd30: u = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
            6'd31: u = '{OP_MUL, R_K1,   R_ERR,  R_T0};
            6'd32: u = '{OP_ADD, R_BIAS, R_T0,   R_BIAS};
            default: u = '{OP_MOV, R_T0, R_T0, R_T0};
        endcase
        return u;
    endfunction

    localparam int unsigned LAST_PC = PROG_LEN;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W+1:0] hi;
        logic signed [DATA_W+1:0] lo;
        hi = (DATA_W+2)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - (DATA_W+2)'(1);
        if (v > hi)
            return hi[DATA_W-1:0];
        else if (v < lo)
            return lo[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/takf_stream_if.sv -----
// Interface: valid/ready stream channel with a generic payload
interface takf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/takf_datapath.sv -----
// Datapath: register file, saturating ALU, shared multiplier and serial divider
module takf_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  takf_pkg::dp_cmd_t                  cmd,
    output takf_pkg::dp_status_t               status,
    input  logic signed [takf_pkg::DATA_W-1:0] in_meas,
    input  logic signed [takf_pkg::DATA_W-1:0] in_rate,
    input  logic        [16:0]                 cfg_dt,
    input  logic        [30:0]                 cfg_qa,
    input  logic        [30:0]                 cfg_qg,
    input  logic        [30:0]                 cfg_rn,
    input  logic signed [takf_pkg::DATA_W-1:0] cfg_c,
    output logic signed [takf_pkg::DATA_W-1:0] out_angle,
    output logic signed [takf_pkg::DATA_W-1:0] out_bias,
    output logic signed [takf_pkg::DATA_W-1:0] out_rate
);
    localparam int unsigned W = takf_pkg::DATA_W;
    localparam int unsigned NUM_W = W + FRAC_BITS;
    localparam int unsigned QW = NUM_W + 1;
    localparam int unsigned CNT_W = $clog2(QW + 1);

    typedef takf_pkg::reg_sel_t reg_sel_t_w;

    logic signed [W-1:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] meas_reg, rate_reg, err_reg, d0_reg, d1_reg;
    logic signed [W-1:0] pc0_reg, pc1_reg, e_reg, k0_reg, k1_reg, tt1_reg, t0_reg;
    logic signed [W-1:0] op_a, op_b, result;
    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] prod_shift;
    logic                 wr_en;

    // Divider state
    logic                 div_busy_reg;
    logic [CNT_W-1:0]     div_cnt_reg;
    logic [QW-1:0]        div_num_reg;
    logic [W:0]           div_den_reg;
    logic [W+1:0]         div_rem_reg;
    logic [QW-1:0]        div_quo_reg;
    logic                 div_neg_reg;
    logic                 div_zero_reg;
    logic                 div_done_reg;
    reg_sel_t_w           div_dst_reg;

    function automatic logic signed [W-1:0] rd(input takf_pkg::reg_sel_t s,
        input logic signed [W-1:0] ang, bias, p00, p01, p10, p11, meas, rate,
        input logic signed [W-1:0] err, d0, d1, pc0, pc1, e, k0, k1, tt1, t0,
        input logic [16:0] dt, input logic [30:0] qa, qg, rn,
        input logic signed [W-1:0] c);
        logic signed [W-1:0] v;
        v = '0;
        case (s)
            takf_pkg::R_ANG:  v = ang;
            takf_pkg::R_BIAS: v = bias;
            takf_pkg::R_P00:  v = p00;
            takf_pkg::R_P01:  v = p01;
            takf_pkg::R_P10:  v = p10;
            takf_pkg::R_P11:  v = p11;
            takf_pkg::R_MEAS: v = meas;
            takf_pkg::R_RATE: v = rate;
            takf_pkg::R_DT:   v = W'(dt);
            takf_pkg::R_QA:   v = W'(qa);
            takf_pkg::R_QG:   v = W'(qg);
            takf_pkg::R_RN:   v = W'(rn);
            takf_pkg::R_C:    v = c;
            takf_pkg::R_T0:   v = t0;
            takf_pkg::R_ERR:  v = err;
            takf_pkg::R_D0:   v = d0;
            takf_pkg::R_D1:   v = d1;
            takf_pkg::R_PC0:  v = pc0;
            takf_pkg::R_PC1:  v = pc1;
            takf_pkg::R_E:    v = e;
            takf_pkg::R_K0:   v = k0;
            takf_pkg::R_K1:   v = k1;
            takf_pkg::R_TT1:  v = tt1;
            default:          v = '0;
        endcase
        return v;
    endfunction

    assign op_a = rd(cmd.src_a, ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg,
        meas_reg, rate_reg, err_reg, d0_reg, d1_reg, pc0_reg, pc1_reg, e_reg, k0_reg,
        k1_reg, tt1_reg, t0_reg, cfg_dt, cfg_qa, cfg_qg, cfg_rn, cfg_c);
    assign op_b = rd(cmd.src_b, ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg,
        meas_reg, rate_reg, err_reg, d0_reg, d1_reg, pc0_reg, pc1_reg, e_reg, k0_reg,
        k1_reg, tt1_reg, t0_reg, cfg_dt, cfg_qa, cfg_qg, cfg_rn, cfg_c);

    assign prod = (2*W)'(op_a) * (2*W)'(op_b);
    assign prod_shift = prod >>> FRAC_BITS;

    always_comb
    begin
        result = op_a;
        case (cmd.op)
            takf_pkg::OP_ADD: result = takf_pkg::sat32((W+2)'(op_a) + (W+2)'(op_b));
            takf_pkg::OP_SUB: result = takf_pkg::sat32((W+2)'(op_a) - (W+2)'(op_b));
            takf_pkg::OP_NEG: result = takf_pkg::sat32(-(W+2)'(op_a));
            takf_pkg::OP_MUL:
            begin
                if (prod_shift > (2*W)'(signed'({1'b0, {(W-1){1'b1}}})))
                    result = {1'b0, {(W-1){1'b1}}};
                else if (prod_shift < -(2*W)'(signed'({1'b0, {(W-1){1'b1}}})) - (2*W)'(1))
                    result = {1'b1, {(W-1){1'b0}}};
                else
                    result = prod_shift[W-1:0];
            end
            default:          result = op_a;
        endcase
    end

    assign wr_en = cmd.start && (cmd.op != takf_pkg::OP_DIV);

    // Restoring division on magnitudes, one quotient bit per cycle
    logic [W+1:0] rem_shift;
    logic [W+1:0] rem_sub;
    logic [QW-1:0] num_mag;
    logic signed [NUM_W:0] num_full;
    logic [W:0] den_mag;
    logic signed [QW:0] quo_signed;
    logic signed [W-1:0] div_result;

    assign num_full = (NUM_W+1)'(op_a) <<< FRAC_BITS;
    assign num_mag = num_full[NUM_W] ? QW'(-num_full) : QW'(num_full);
    assign den_mag = op_b[W-1] ? (W+1)'(-(W+1)'(op_b)) : (W+1)'(op_b);
    assign rem_shift = {div_rem_reg[W:0], div_num_reg[QW-1]};
    assign rem_sub = rem_shift - (W+2)'(div_den_reg);
    assign quo_signed = div_neg_reg ? -(QW+1)'(div_quo_reg) : (QW+1)'(div_quo_reg);

    always_comb
    begin
        if (div_zero_reg)
            div_result = '0;
        else if (quo_signed > (QW+1)'(signed'({1'b0, {(W-1){1'b1}}})))
            div_result = {1'b0, {(W-1){1'b1}}};
        else if (quo_signed < -(QW+1)'(signed'({1'b0, {(W-1){1'b1}}})) - (QW+1)'(1))
            div_result = {1'b1, {(W-1){1'b0}}};
        else
            div_result = quo_signed[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.start && cmd.op == takf_pkg::OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= CNT_W'(QW);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && cmd.op == takf_pkg::OP_DIV)
        begin
            div_num_reg  <= num_mag;
            div_den_reg  <= den_mag;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
            div_neg_reg  <= op_a[W-1] ^ op_b[W-1];
            div_zero_reg <= (op_b == '0);
            div_dst_reg  <= cmd.dst;
        end
        else if (div_busy_reg)
        begin
            div_num_reg <= {div_num_reg[QW-2:0], 1'b0};
            if (!rem_sub[W+1])
            begin
                div_rem_reg <= rem_sub;
                div_quo_reg <= {div_quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= rem_shift;
                div_quo_reg <= {div_quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign status.busy = div_busy_reg || (cmd.start && cmd.op == takf_pkg::OP_DIV);

    logic                 wb_en;
    takf_pkg::reg_sel_t   wb_dst;
    logic signed [W-1:0]  wb_val;

    assign wb_en  = wr_en || div_done_reg;
    assign wb_dst = div_done_reg ? div_dst_reg : cmd.dst;
    assign wb_val = div_done_reg ? div_result : result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
        end
        else if (wb_en)
        begin
            case (wb_dst)
                takf_pkg::R_ANG:  ang_reg  <= wb_val;
                takf_pkg::R_BIAS: bias_reg <= wb_val;
                takf_pkg::R_P00:  p00_reg  <= wb_val;
                takf_pkg::R_P01:  p01_reg  <= wb_val;
                takf_pkg::R_P10:  p10_reg  <= wb_val;
                takf_pkg::R_P11:  p11_reg  <= wb_val;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            meas_reg <= in_meas;
            rate_reg <= in_rate;
        end
        if (wb_en)
        begin
            case (wb_dst)
                takf_pkg::R_T0:  t0_reg  <= wb_val;
                takf_pkg::R_ERR: err_reg <= wb_val;
                takf_pkg::R_D0:  d0_reg  <= wb_val;
                takf_pkg::R_D1:  d1_reg  <= wb_val;
                takf_pkg::R_PC0: pc0_reg <= wb_val;
                takf_pkg::R_PC1: pc1_reg <= wb_val;
                takf_pkg::R_E:   e_reg   <= wb_val;
                takf_pkg::R_K0:  k0_reg  <= wb_val;
                takf_pkg::R_K1:  k1_reg  <= wb_val;
                takf_pkg::R_TT1: tt1_reg <= wb_val;
                default:         ;
            endcase
        end
    end

    assign out_angle = ang_reg;
    assign out_bias  = bias_reg;
    assign out_rate  = takf_pkg::sat32((W+2)'(rate_reg) - (W+2)'(bias_reg));
endmodule

// ----- rtl/takf_controller.sv -----
// Controller: sequences the update program and the stream handshakes
module takf_controller (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_load,
    output takf_pkg::dp_cmd_t        cmd,
    input  takf_pkg::dp_status_t     status
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [takf_pkg::PC_W-1:0]       pc_reg, pc_next;
    logic                            out_valid_reg, out_valid_next;
    takf_pkg::ucode_t                u;

    assign u = takf_pkg::program_step(pc_reg);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        cmd            = '{1'b0, u.op, u.a, u.b, u.d, 1'b0};
        in_ready       = 1'b0;
        out_load       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    pc_next     = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.start = 1'b1;
                if (u.op == takf_pkg::OP_DIV)
                    state_next = ST_WAIT;
                else if (pc_reg == takf_pkg::PC_W'(takf_pkg::LAST_PC - 1))
                    state_next = ST_DONE;
                else
                    pc_next = pc_reg + takf_pkg::PC_W'(1);
            end
            ST_WAIT:
            begin
                if (!status.busy)
                begin
                    pc_next    = pc_reg + takf_pkg::PC_W'(1);
                    state_next = ST_RUN;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- rtl/tilt_angle_kalman_filter.sv -----
// Top level: two-state tilt angle Kalman filter with config registers
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------
//  in_ch    | in  | measured_angle, gyro_rate
//  out_ch   | out | angle_estimate, bias_estimate, corrected_rate
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata
//
// From acceptance to result load an item goes through the accept step,
// 33 microcode steps on one shared ALU and multiplier, two serial divisions
// that each produce W+FRAC_BITS+1 = 49 quotient bits and then write back,
// and the output load.
// Reset clears state and covariance to zero and sets the config registers to their defaults.
// A result waits in an output register; the next item is taken while it waits.
module tilt_angle_kalman_filter #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    takf_stream_if.sink                   in_ch,
    takf_stream_if.source                 out_ch,
    input  logic                          cfg_we,
    input  logic [takf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [takf_pkg::DATA_W-1:0]   cfg_wdata
);
    localparam int unsigned W = takf_pkg::DATA_W;

    logic [16:0]         dt_reg;
    logic [30:0]         qa_reg, qg_reg, rn_reg;
    logic signed [W-1:0] c_reg;
    takf_pkg::dp_cmd_t    cmd;
    takf_pkg::dp_status_t status;
    logic                out_load;
    logic signed [W-1:0] a_est, b_est, c_rate;
    logic signed [W-1:0] oa_reg, ob_reg, oc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= 17'd328;
            qa_reg <= 31'd66;
            qg_reg <= 31'd328;
            rn_reg <= 31'd32768;
            c_reg  <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                takf_pkg::REG_SAMPLE_PERIOD: dt_reg <= cfg_wdata[16:0];
                takf_pkg::REG_ANGLE_NOISE:   qa_reg <= cfg_wdata[30:0];
                takf_pkg::REG_BIAS_NOISE:    qg_reg <= cfg_wdata[30:0];
                takf_pkg::REG_MEASURE_NOISE: rn_reg <= cfg_wdata[30:0];
                takf_pkg::REG_OBSERVE_GAIN:  c_reg  <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    takf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_load  (out_load),
        .cmd       (cmd),
        .status    (status)
    );

    takf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_meas   (in_ch.data.measured_angle),
        .in_rate   (in_ch.data.gyro_rate),
        .cfg_dt    (dt_reg),
        .cfg_qa    (qa_reg),
        .cfg_qg    (qg_reg),
        .cfg_rn    (rn_reg),
        .cfg_c     (c_reg),
        .out_angle (a_est),
        .out_bias  (b_est),
        .out_rate  (c_rate)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            oa_reg <= a_est;
            ob_reg <= b_est;
            oc_reg <= c_rate;
        end
    end

    assign out_ch.data.angle_estimate = oa_reg;
    assign out_ch.data.bias_estimate  = ob_reg;
    assign out_ch.data.corrected_rate = oc_reg;

    a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !out_load)
        else $error("result overwritten while waiting");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !in_ch.ready)
        else $error("input taken during update");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_ch.valid)
        else $error("result lost");
endmodule

// ----- bench/takf_tb_pkg.sv -----
// Transaction payload types shared by the tilt filter testbench files
package takf_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
        logic signed [31:0] corrected_rate;
    } estimate_t;

endpackage

// ----- bench/takf_checker.sv -----
// Checker: tracks register writes, predicts filter updates and compares results
module takf_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    takf_stream_if                         in_ch,
    takf_stream_if                         out_ch,
    input  logic                           cfg_we,
    input  logic [takf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [takf_pkg::DATA_W-1:0]    cfg_wdata,
    output int                             fails,
    output int                             pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    logic signed [31:0]     dt, q_angle, q_bias, r_meas, c_gain;
    logic signed [31:0]     angle_q, bias_q;
    logic signed [31:0]     p00_q, p01_q, p10_q, p11_q;
    takf_tb_pkg::estimate_t estimates_due[$];

    function automatic logic signed [31:0] clip(input logic signed [63:0] v);
        if (v > MAXV)
            return MAXV[31:0];
        if (v < MINV)
            return MINV[31:0];
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_s(input logic signed [31:0] a, b);
        return clip(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] sub_s(input logic signed [31:0] a, b);
        return clip(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a, b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clip(p >>> FB);
    endfunction

    function automatic logic signed [31:0] div_q(input logic signed [31:0] n, d);
        logic signed [63:0] num;
        if (d == 0)
            return 32'sd0;
        num = 64'(n) <<< FB;
        return clip(num / 64'(d));
    endfunction

    function automatic takf_tb_pkg::estimate_t kalman_update(input takf_tb_pkg::sample_t s);
        logic signed [31:0] err, d0, d1, pc0, pc1, e, k0, k1, tt1;
        logic signed [31:0] n00, n01, n10, n11;
        takf_tb_pkg::estimate_t r;
        angle_q = add_s(angle_q, mul_q(sub_s(s.gyro_rate, bias_q), dt));
        err = sub_s(s.measured_angle, angle_q);
        d0 = sub_s(sub_s(q_angle, p01_q), p10_q);
        d1 = clip(-64'(p11_q));
        p00_q = add_s(p00_q, mul_q(d0, dt));
        p01_q = add_s(p01_q, mul_q(d1, dt));
        p10_q = add_s(p10_q, mul_q(d1, dt));
        p11_q = add_s(p11_q, mul_q(q_bias, dt));
        pc0 = mul_q(c_gain, p00_q);
        pc1 = mul_q(c_gain, p10_q);
        e = add_s(r_meas, mul_q(c_gain, pc0));
        k0 = div_q(pc0, e);
        k1 = div_q(pc1, e);
        tt1 = mul_q(c_gain, p01_q);
        n00 = sub_s(p00_q, mul_q(k0, pc0));
        n01 = sub_s(p01_q, mul_q(k0, tt1));
        n10 = sub_s(p10_q, mul_q(k1, pc0));
        n11 = sub_s(p11_q, mul_q(k1, tt1));
        p00_q = n00;
        p01_q = n01;
        p10_q = n10;
        p11_q = n11;
        angle_q = add_s(angle_q, mul_q(k0, err));
        bias_q = add_s(bias_q, mul_q(k1, err));
        r.angle_estimate = angle_q;
        r.bias_estimate = bias_q;
        r.corrected_rate = sub_s(s.gyro_rate, bias_q);
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, want);
        $display("%0t: %s got %h want %h", $realtime, field, got, want);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        takf_tb_pkg::estimate_t want, got;
        if (!rst_n)
        begin
            dt = 32'sd328;
            q_angle = 32'sd66;
            q_bias = 32'sd328;
            r_meas = 32'sd32768;
            c_gain = 32'sd65536;
            angle_q = 0;
            bias_q = 0;
            p00_q = 0;
            p01_q = 0;
            p10_q = 0;
            p11_q = 0;
            estimates_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    takf_pkg::REG_SAMPLE_PERIOD: dt = {15'd0, cfg_wdata[16:0]};
                    takf_pkg::REG_ANGLE_NOISE:   q_angle = {1'b0, cfg_wdata[30:0]};
                    takf_pkg::REG_BIAS_NOISE:    q_bias = {1'b0, cfg_wdata[30:0]};
                    takf_pkg::REG_MEASURE_NOISE: r_meas = {1'b0, cfg_wdata[30:0]};
                    takf_pkg::REG_OBSERVE_GAIN:  c_gain = cfg_wdata;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (estimates_due.size() == 0)
                begin
                    $display("%0t: unexpected result transaction", $realtime);
                    fails++;
                end
                else
                begin
                    want = estimates_due.pop_front();
                    if (got.angle_estimate !== want.angle_estimate)
                        report("angle_estimate", got.angle_estimate, want.angle_estimate);
                    if (got.bias_estimate !== want.bias_estimate)
                        report("bias_estimate", got.bias_estimate, want.bias_estimate);
                    if (got.corrected_rate !== want.corrected_rate)
                        report("corrected_rate", got.corrected_rate, want.corrected_rate);
                end
            end
            if (in_ch.valid && in_ch.ready)
                estimates_due.push_back(kalman_update(in_ch.data));
        end
        pending = estimates_due.size();
    end

endmodule

// ----- bench/tb_tilt_angle_kalman_filter.sv -----
// Testbench top: drives samples and register writes into the tilt Kalman filter
module tb_tilt_angle_kalman_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int DEG = 65536;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [takf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [takf_pkg::DATA_W-1:0]    cfg_wdata;
    int                             fails;
    int                             pending;
    int                             idle_cycles;

    takf_stream_if #(.payload_t(takf_tb_pkg::sample_t))   in_ch();
    takf_stream_if #(.payload_t(takf_tb_pkg::estimate_t)) out_ch();

    tilt_angle_kalman_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    takf_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    function automatic logic [31:0] pick_value(input int scale);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'($urandom_range(0, 3)) - 32'd1;
            default: return 32'($signed($urandom_range(0, 2 * scale)) - scale);
        endcase
    endfunction

    task automatic send(input logic [31:0] meas, input logic [31:0] rate);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= '{measured_angle: meas, gyro_rate: rate};
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] v[5]);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= takf_pkg::CFG_IDX_W'(i);
            cfg_wdata <= v[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_samples(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                send(32'($signed($urandom_range(0, 180 * DEG)) - 90 * DEG),
                     32'($signed($urandom_range(0, 1000 * DEG)) - 500 * DEG));
            else
                send(pick_value(DEG), pick_value(DEG));
        end
    endtask

    initial
    begin
        logic [31:0] cfg[5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(32'sd0, 32'sd0);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h8000_0000, 32'h8000_0000);
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'hFFFF_FFFF, 32'h0000_0001);
        send(32'd10 * DEG, 32'd2 * DEG);
        send(32'h5555_5555, 32'hAAAA_AAAA);
        send(32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // zero innovation variance
        cfg = '{32'd328, 32'd66, 32'd328, 32'd0, 32'd0};
        write_regs(cfg);
        send(32'd5 * DEG, 32'd1 * DEG);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();

        // zero sample period through masked upper bits, junk to unused indexes
        cfg = '{32'h0002_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_regs(cfg);
        for (int i = 5; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= takf_pkg::CFG_IDX_W'(i);
            cfg_wdata <= $urandom();
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        send(32'd3 * DEG, 32'hFFFF_0000);
        send(32'h7FFF_FFFF, 32'h0);
        wait_idle();

        cfg = '{32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF};
        write_regs(cfg);
        send(32'd1, 32'hFFFF_FFFF);
        send(32'h8000_0000, 32'h8000_0000);
        wait_idle();

        cfg = '{32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000};
        write_regs(cfg);
        send(32'd45 * DEG, 32'd7 * DEG);
        send(32'hFFD3_0000, 32'h0);
        wait_idle();

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                cfg = '{32'd328, 32'd66, 32'd328, 32'd32768, 32'd65536};
            else if (phase < 4)
                cfg = '{32'($urandom_range(1, 2000)), 32'($urandom_range(0, 5000)),
                        32'($urandom_range(0, 5000)), 32'($urandom_range(0, 200000)),
                        32'($signed($urandom_range(0, 4 * DEG)) - 2 * DEG)};
            else
                cfg = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            write_regs(cfg);
            random_samples(90);
            wait_idle();
        end

        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule
